// ===== hw/rtl/c3zpa_pkg.sv =====
// shared constants and types for the 3x3 zero-padded convolution block
// no dependencies; used by the channel interfaces and the top level
package c3zpa_pkg;

   localparam int MAX_SIZE_DEF = 32;
   localparam int DATA_W       = 32;
   localparam int TAP_W        = 4;
   localparam int FS_W         = 6;
   localparam int SH_W         = 5;
   localparam int POS_W        = 5;
   localparam int NUM_TAPS     = 9;
   localparam int CSR_AW       = 4;
   localparam int CSR_DW       = 32;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_FRAME_SIZE = 2'd0;
   localparam logic [1:0] REG_IN_SHIFT   = 2'd1;
   localparam logic [1:0] REG_OUT_SHIFT  = 2'd2;

   localparam logic [FS_W-1:0] FRAME_SIZE_RESET = 6'd32;

   // item kinds
   localparam logic MODE_WEIGHT = 1'b0;
   localparam logic MODE_PIXEL  = 1'b1;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [2*DATA_W-1:0] prod_type;

endpackage

// ===== hw/rtl/c3zpa_if.sv =====
// request and response channel interfaces of the convolution block
// depends on c3zpa_pkg
interface c3zpa_req_if;
   import c3zpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [TAP_W-1:0]     tap;
   logic signed [DATA_W-1:0] value;
   logic signed [DATA_W-1:0] prior;
   modport source (output valid, mode, tap, value, prior, input ready);
   modport sink (input valid, mode, tap, value, prior, output ready);
endinterface

interface c3zpa_rsp_if;
   import c3zpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [DATA_W-1:0] sum;
   logic [POS_W-1:0]     out_row;
   logic [POS_W-1:0]     out_col;
   logic                 last_of_run;
   logic                 frame_end;
   modport source (output valid, sum, out_row, out_col, last_of_run, frame_end, input ready);
   modport sink (input valid, sum, out_row, out_col, last_of_run, frame_end, output ready);
endinterface

// ===== hw/rtl/conv3x3_zero_pad_accumulate.sv =====
// top level of the streaming 3x3 same-padded convolution with prior accumulation
// depends on c3zpa_pkg and the channel interfaces in c3zpa_if.sv
//
// Nine weights are loaded (mode 0), then a square frame of pixels streams in raster
// order (mode 1), each with the prior accumulator of its position. A pixel is taken
// every cycle while no earlier pixel still has results pending; it causes up to four
// results (one on an inner pixel, two at the end of a row or on the last row, four on
// the bottom-right pixel), and the result path delivers one result per cycle while the
// response channel is ready, so each pixel holds back the next one until its results
// have been issued. The window stage walks those results. From a pixel's transaction
// to its first result, the input register (with line buffer read) takes the pixel, then
// window shift, operand select, nine multipliers and the sum each add a register. Two
// rows of pixels (three-row buffer) and two rows of priors live in memories read at the
// current column; their contents are undefined until written, with no clearing.
module conv3x3_zero_pad_accumulate #(
   parameter int MAX_SIZE = c3zpa_pkg::MAX_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   c3zpa_req_if.sink                      req_bus,
   c3zpa_rsp_if.source                    rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [c3zpa_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [c3zpa_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [c3zpa_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                           csr_pready
);
   import c3zpa_pkg::*;

   localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;   // row / column index
   localparam int NW = $clog2(MAX_SIZE + 1);                     // frame size

   // ---------------- configuration registers ----------------
   logic [FS_W-1:0] fs_ff;
   logic [SH_W-1:0] ish_ff, osh_ff;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff  <= FRAME_SIZE_RESET;
         ish_ff <= '0;
         osh_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_FRAME_SIZE: fs_ff  <= csr_pwdata[FS_W-1:0];
            REG_IN_SHIFT:   ish_ff <= csr_pwdata[SH_W-1:0];
            REG_OUT_SHIFT:  osh_ff <= csr_pwdata[SH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_FRAME_SIZE: csr_prdata = CSR_DW'(fs_ff);
         REG_IN_SHIFT:   csr_prdata = CSR_DW'(ish_ff);
         REG_OUT_SHIFT:  csr_prdata = CSR_DW'(osh_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // effective frame size: zero acts as one, clamp at the buffer size
   logic [NW-1:0] n_eff;
   always_comb begin
      if (fs_ff == '0)
         n_eff = NW'(1);
      else if (int'(fs_ff) > MAX_SIZE)
         n_eff = NW'(MAX_SIZE);
      else
         n_eff = NW'(fs_ff);
   end

   // ---------------- accept: position counters and buffers ----------------
   logic          acc, pix_acc;
   logic [IW-1:0] row_ff, col_ff, cur_r, cur_c;
   logic [1:0]    rm3_ff, cur_m3, m3_m1, m3_m2;
   logic          restart, last_r, last_c;
   logic [NW-1:0] n_m1;
   logic [3:0]    mask_in;
   logic          s1_ready;

   assign acc           = req_bus.valid && s1_ready;
   assign pix_acc       = acc && (req_bus.mode == MODE_PIXEL);
   assign req_bus.ready = s1_ready;

   always_comb begin
      // a frame size that shrinks below the current position restarts at the top-left corner
      restart = (NW'(row_ff) >= n_eff) || (NW'(col_ff) >= n_eff);
      cur_r   = restart ? '0 : row_ff;
      cur_c   = restart ? '0 : col_ff;
      cur_m3  = restart ? 2'd0 : rm3_ff;
      m3_m1   = (cur_m3 == 2'd0) ? 2'd2 : cur_m3 - 2'd1;
      m3_m2   = (cur_m3 == 2'd0) ? 2'd1 : ((cur_m3 == 2'd1) ? 2'd2 : 2'd0);
      n_m1    = n_eff - NW'(1);
      last_r  = (NW'(cur_r) == n_m1);
      last_c  = (NW'(cur_c) == n_m1);
      // results in raster order: (R-1,C-1) (R-1,C) (R,C-1) (R,C)
      mask_in[0] = (cur_r != '0) && (cur_c != '0);
      mask_in[1] = (cur_r != '0) && last_c;
      mask_in[2] = last_r && (cur_c != '0);
      mask_in[3] = last_r && last_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         rm3_ff <= 2'd0;
      end else if (pix_acc) begin
         if (last_c) begin
            col_ff <= '0;
            row_ff <= last_r ? '0 : cur_r + IW'(1);
            rm3_ff <= (last_r || cur_m3 == 2'd2) ? 2'd0 : cur_m3 + 2'd1;
         end else begin
            col_ff <= cur_c + IW'(1);
            row_ff <= cur_r;
            rm3_ff <= cur_m3;
         end
      end
   end

   // three pixel rows and two prior rows, read at the current column
   logic [DATA_W-1:0] line_mem  [0:2][0:MAX_SIZE-1];
   logic [DATA_W-1:0] prior_mem [0:1][0:MAX_SIZE-1];
   logic [DATA_W-1:0] top_rd_ff, mid_rd_ff, pup_rd_ff;

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         line_mem[cur_m3][cur_c]   <= req_bus.value;
         prior_mem[cur_r[0]][cur_c] <= req_bus.prior;
         top_rd_ff <= line_mem[m3_m2][cur_c];
         mid_rd_ff <= line_mem[m3_m1][cur_c];
         pup_rd_ff <= prior_mem[~cur_r[0]][cur_c];
      end
   end

   // input register
   logic              s1_v_ff, s1_mode_ff;
   logic [TAP_W-1:0]  s1_tap_ff;
   word_type          s1_val_ff, s1_pri_ff;
   logic [IW-1:0]     s1_r_ff, s1_c_ff;
   logic [NW-1:0]     s1_n_ff;
   logic [3:0]        s1_mask_ff;
   logic              s2_take;

   assign s1_ready = !s1_v_ff || s2_take;

   always_ff @(posedge clock) begin
      if (reset)
         s1_v_ff <= 1'b0;
      else if (acc)
         s1_v_ff <= 1'b1;
      else if (s2_take)
         s1_v_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_mode_ff <= req_bus.mode;
         s1_tap_ff  <= req_bus.tap;
         s1_val_ff  <= req_bus.value;
         s1_pri_ff  <= req_bus.prior;
         s1_r_ff    <= cur_r;
         s1_c_ff    <= cur_c;
         s1_n_ff    <= n_eff;
         s1_mask_ff <= mask_in;
      end
   end

   // ---------------- window stage: shift the 3x3 window, walk results ----------------
   word_type          win_ff [0:2][0:2];      // rows R-2..R, columns C-2..C
   word_type          wt_ff  [0:NUM_TAPS-1];
   word_type          pu_prev_ff, pu_cur_ff, pc_prev_ff, pc_cur_ff;
   logic [IW-1:0]     s2_r_ff, s2_c_ff;
   logic [NW-1:0]     s2_n_ff;
   logic [3:0]        pend_ff, pend_in, pend_after, low;
   logic              fire, rdy3;

   always_comb begin
      low        = pend_ff & (~pend_ff + 4'd1);
      fire       = (pend_ff != 4'd0) && rdy3;
      pend_after = fire ? (pend_ff & ~low) : pend_ff;
      s2_take    = s1_v_ff && (pend_after == 4'd0);
      if (s2_take)
         pend_in = (s1_mode_ff == MODE_PIXEL) ? s1_mask_ff : 4'd0;
      else
         pend_in = pend_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 4'd0;
         for (int k = 0; k < NUM_TAPS; k++)
            wt_ff[k] <= '0;
      end else begin
         pend_ff <= pend_in;
         if (s2_take && s1_mode_ff == MODE_WEIGHT && int'(s1_tap_ff) < NUM_TAPS)
            wt_ff[s1_tap_ff] <= s1_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take && s1_mode_ff == MODE_PIXEL) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         // pixels are kept pre-shifted; in_shift is to stay static while a frame runs, which the block does not enforce
         win_ff[0][2] <= $signed(top_rd_ff) >>> ish_ff;
         win_ff[1][2] <= $signed(mid_rd_ff) >>> ish_ff;
         win_ff[2][2] <= s1_val_ff >>> ish_ff;
         pu_prev_ff   <= pu_cur_ff;
         pu_cur_ff    <= $signed(pup_rd_ff);
         pc_prev_ff   <= pc_cur_ff;
         pc_cur_ff    <= s1_pri_ff;
         s2_r_ff      <= s1_r_ff;
         s2_c_ff      <= s1_c_ff;
         s2_n_ff      <= s1_n_ff;
      end
   end

   // operand select for the result at the head of the pending set
   logic              ro, co, job_last, job_fend;
   logic [IW-1:0]     job_r, job_c;
   logic [NW-1:0]     s2_nm1;
   word_type          op_px [0:NUM_TAPS-1];
   word_type          op_wt [0:NUM_TAPS-1];
   word_type          job_pri;

   always_comb begin
      int  i, j;
      logic rok, cok;
      ro       = low[2] | low[3];
      co       = low[1] | low[3];
      job_last = ((pend_ff & ~low) == 4'd0);
      job_fend = low[3];
      job_r    = ro ? s2_r_ff : s2_r_ff - IW'(1);
      job_c    = co ? s2_c_ff : s2_c_ff - IW'(1);
      s2_nm1   = s2_n_ff - NW'(1);
      job_pri  = ro ? (co ? pc_cur_ff : pc_prev_ff) : (co ? pu_cur_ff : pu_prev_ff);
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            i   = dr + int'(ro);
            j   = dc + int'(co);
            // zero padding outside the frame
            rok = !((dr == 0 && job_r == '0) || (dr == 2 && NW'(job_r) == s2_nm1));
            cok = !((dc == 0 && job_c == '0) || (dc == 2 && NW'(job_c) == s2_nm1));
            if (i < 3 && j < 3 && rok && cok)
               op_px[3*dr+dc] = win_ff[i][j];
            else
               op_px[3*dr+dc] = '0;
            op_wt[3*dr+dc] = wt_ff[3*dr+dc] >>> ish_ff;
         end
      end
   end

   // ---------------- operand register ----------------
   logic              s3_v_ff, s3_last_ff, s3_fend_ff, rdy4;
   word_type          s3_px_ff [0:NUM_TAPS-1];
   word_type          s3_wt_ff [0:NUM_TAPS-1];
   word_type          s3_pri_ff;
   logic [IW-1:0]     s3_r_ff, s3_c_ff;

   assign rdy3 = !s3_v_ff || rdy4;

   always_ff @(posedge clock) begin
      if (reset)
         s3_v_ff <= 1'b0;
      else if (rdy3)
         s3_v_ff <= fire;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int k = 0; k < NUM_TAPS; k++) begin
            s3_px_ff[k] <= op_px[k];
            s3_wt_ff[k] <= op_wt[k];
         end
         s3_pri_ff  <= job_pri;
         s3_r_ff    <= job_r;
         s3_c_ff    <= job_c;
         s3_last_ff <= job_last;
         s3_fend_ff <= job_fend;
      end
   end

   // ---------------- product register: nine full-width products ----------------
   logic              s4_v_ff, s4_last_ff, s4_fend_ff, rdy5;
   prod_type          s4_prod_ff [0:NUM_TAPS-1];
   word_type          s4_pri_ff;
   logic [IW-1:0]     s4_r_ff, s4_c_ff;

   assign rdy4 = !s4_v_ff || rdy5;

   always_ff @(posedge clock) begin
      if (reset)
         s4_v_ff <= 1'b0;
      else if (rdy4)
         s4_v_ff <= s3_v_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy4 && s3_v_ff) begin
         // signed 32 x 32 multiply with a 64-bit product
         for (int k = 0; k < NUM_TAPS; k++)
            s4_prod_ff[k] <= s3_px_ff[k] * s3_wt_ff[k];
         s4_pri_ff  <= s3_pri_ff;
         s4_r_ff    <= s3_r_ff;
         s4_c_ff    <= s3_c_ff;
         s4_last_ff <= s3_last_ff;
         s4_fend_ff <= s3_fend_ff;
      end
   end

   // ---------------- result register: scale, truncate, wrap-add ----------------
   logic              o_v_ff, o_last_ff, o_fend_ff;
   word_type          o_sum_ff, sum_in;
   logic [IW-1:0]     o_r_ff, o_c_ff;

   assign rdy5 = !o_v_ff || rsp_bus.ready;

   always_comb begin
      sum_in = s4_pri_ff;
      for (int k = 0; k < NUM_TAPS; k++)
         sum_in = sum_in + DATA_W'(s4_prod_ff[k] >>> osh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset)
         o_v_ff <= 1'b0;
      else if (rdy5)
         o_v_ff <= s4_v_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy5 && s4_v_ff) begin
         o_sum_ff  <= sum_in;
         o_r_ff    <= s4_r_ff;
         o_c_ff    <= s4_c_ff;
         o_last_ff <= s4_last_ff;
         o_fend_ff <= s4_fend_ff;
      end
   end

   assign rsp_bus.valid       = o_v_ff;
   assign rsp_bus.sum         = o_sum_ff;
   assign rsp_bus.out_row     = POS_W'(o_r_ff);
   assign rsp_bus.out_col     = POS_W'(o_c_ff);
   assign rsp_bus.last_of_run = o_last_ff;
   assign rsp_bus.frame_end   = o_fend_ff;

   // ---------------- assertions ----------------
   // the bottom-right result is always the last one its pixel causes
   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && o_fend_ff) |-> o_last_ff)
      else $error("frame end without last of run");

   // the bottom-right position lies on the diagonal
   a_fend_diag: assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && o_fend_ff) |-> (o_r_ff == o_c_ff))
      else $error("frame end off the diagonal");

   // after a pixel the position counters stay inside the frame
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      pix_acc |=> ((NW'(row_ff) < $past(n_eff)) && (NW'(col_ff) < $past(n_eff))))
      else $error("position counter outside frame");

   // a pixel taken by the window stage brings its whole result set with it
   a_pend_load: assert property (@(posedge clock) disable iff (reset)
      (s2_take && s1_mode_ff == MODE_PIXEL) |=> (pend_ff == $past(s1_mask_ff)))
      else $error("pending result set lost");

endmodule
